// ===== rtl/bdq_pkg.sv =====
package bdq_pkg;

  localparam int DATA_W        = 32;
  localparam int REQ_W         = 3;
  localparam int COUNT_OUT_W   = 5;
  localparam int DEPTH_DEFAULT = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_PEEK_BACK  = 3'd4,
    REQ_PEEK_FRONT = 3'd5
  } req_t;

endpackage

// ===== rtl/bdq_ram.sv =====
module bdq_ram #(
  parameter int DEPTH  = bdq_pkg::DEPTH_DEFAULT,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [ADDR_W-1:0]          addr,
  input  logic [bdq_pkg::DATA_W-1:0] wdata,
  output logic [bdq_pkg::DATA_W-1:0] rdata
);
  import bdq_pkg::*;

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/bounded_deque_top.sv =====
// channel    | qualifier          | signals
// -----------+--------------------+-----------------------------------------------
// request    | start & !busy      | req_type, push_value
// result     | done (one cycle)   | result_value, ok, entry_count, is_empty
// config     | empty_value_we     | empty_value_in
//
// The ring memory is accessed at the accept edge of a request, and its
// registered read data forms the result in the following cycle, while busy
// is high. No new request is accepted while busy is high.
// Reset (rst, synchronous) empties the deque and clears the empty value.
// The receiver cannot stall; each result is shown for exactly one cycle.
module bounded_deque_top #(
  parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [bdq_pkg::REQ_W-1:0]       req_type,
  input  logic signed [bdq_pkg::DATA_W-1:0] push_value,
  input  logic                            empty_value_we,
  input  logic signed [bdq_pkg::DATA_W-1:0] empty_value_in,
  output logic                            done,
  output logic signed [bdq_pkg::DATA_W-1:0] result_value,
  output logic                            ok,
  output logic [bdq_pkg::COUNT_OUT_W-1:0] entry_count,
  output logic                            is_empty
);
  import bdq_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  logic [ADDR_W-1:0] front, front_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [DATA_W-1:0] empty_reg;
  logic              pend;
  logic              pend_mem;
  logic              pend_ok;
  logic [DATA_W-1:0] pend_fixed;

  logic              accept;
  logic              is_full, is_zero;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [DATA_W-1:0] mem_rdata;
  logic [ADDR_W-1:0] offset;
  logic [ADDR_W:0]   slot_sum;
  logic [ADDR_W-1:0] slot;
  logic [ADDR_W-1:0] front_dec, front_inc;
  logic              req_ok, req_mem, req_empty_val;
  logic [CNT_W+COUNT_OUT_W-1:0] count_ext;

  assign accept  = start && !busy;
  assign busy    = pend;
  assign is_full = (count == CNT_W'(DEPTH));
  assign is_zero = (count == '0);

  assign front_dec = (front == '0) ? ADDR_W'(DEPTH - 1) : front - 1'b1;
  assign front_inc = (front == ADDR_W'(DEPTH - 1)) ? '0 : front + 1'b1;

  always_comb begin
    offset       = ADDR_W'(count - 1'b1);
    mem_we       = 1'b0;
    req_ok       = 1'b0;
    req_mem      = 1'b0;
    req_empty_val = 1'b0;
    front_next   = front;
    count_next   = count;
    unique case (req_type)
      REQ_PUSH_BACK: begin
        offset = ADDR_W'(count);
        if (!is_full) begin
          mem_we     = accept;
          req_ok     = 1'b1;
          count_next = count + 1'b1;
        end
      end
      REQ_PUSH_FRONT: begin
        if (!is_full) begin
          mem_we     = accept;
          req_ok     = 1'b1;
          front_next = front_dec;
          count_next = count + 1'b1;
        end
      end
      REQ_POP_BACK, REQ_PEEK_BACK: begin
        if (is_zero) begin
          req_empty_val = 1'b1;
        end else begin
          req_ok  = 1'b1;
          req_mem = 1'b1;
          if (req_type == REQ_POP_BACK) begin
            count_next = count - 1'b1;
          end
        end
      end
      REQ_POP_FRONT, REQ_PEEK_FRONT: begin
        if (is_zero) begin
          req_empty_val = 1'b1;
        end else begin
          req_ok  = 1'b1;
          req_mem = 1'b1;
          if (req_type == REQ_POP_FRONT) begin
            front_next = front_inc;
            count_next = count - 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // slot = (front + offset) mod DEPTH; the sum stays below 2*DEPTH whenever the slot is used
  assign slot_sum = {1'b0, front} + {1'b0, offset};
  assign slot = (slot_sum >= (ADDR_W+1)'(DEPTH)) ?
                ADDR_W'(slot_sum - (ADDR_W+1)'(DEPTH)) : ADDR_W'(slot_sum);

  always_comb begin
    unique case (req_type)
      REQ_PUSH_FRONT:                mem_addr = front_dec;
      REQ_POP_FRONT, REQ_PEEK_FRONT: mem_addr = front;
      default:                       mem_addr = slot;
    endcase
  end

  bdq_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (push_value),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      front     <= '0;
      count     <= '0;
      empty_reg <= '0;
      pend      <= 1'b0;
    end else begin
      if (empty_value_we) begin
        empty_reg <= empty_value_in;
      end
      pend <= accept;
      if (accept) begin
        front <= front_next;
        count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_mem   <= req_mem;
      pend_ok    <= req_ok;
      pend_fixed <= req_empty_val ? empty_reg : '0;
    end
  end

  assign count_ext    = (CNT_W+COUNT_OUT_W)'(count);
  assign done         = pend;
  assign result_value = pend_mem ? mem_rdata : pend_fixed;
  assign ok           = pend_ok;
  assign entry_count  = count_ext[COUNT_OUT_W-1:0];
  assign is_empty     = is_zero;

endmodule

// ===== rtl/bdq_check.sv =====
module bdq_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic                            busy,
  input logic [bdq_pkg::REQ_W-1:0]       req_type,
  input logic                            done,
  input logic signed [bdq_pkg::DATA_W-1:0] result_value,
  input logic                            ok,
  input logic [bdq_pkg::COUNT_OUT_W-1:0] entry_count,
  input logic                            is_empty
);
  import bdq_pkg::*;

  a_request_answered: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done)
    else $error("accepted request gave no result");

  a_single_result: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result shown for more than one cycle");

  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (entry_count == '0)))
    else $error("empty flag disagrees with count");

  a_push_zero: assert property (@(posedge clk) disable iff (rst)
    done && ($past(req_type) == REQ_PUSH_BACK || $past(req_type) == REQ_PUSH_FRONT)
      |-> result_value == '0)
    else $error("push returned a nonzero value");

  a_push_ok_count: assert property (@(posedge clk) disable iff (rst)
    done && ok && ($past(req_type) == REQ_PUSH_BACK || $past(req_type) == REQ_PUSH_FRONT)
      |-> !is_empty)
    else $error("successful push left deque empty");

endmodule

bind bounded_deque_top bdq_check u_bdq_check (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .req_type     (req_type),
  .done         (done),
  .result_value (result_value),
  .ok           (ok),
  .entry_count  (entry_count),
  .is_empty     (is_empty)
);
